### sv/arc_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arc bounding box block
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ARC_BOUNDING_BOX_MACROS_SVH
`define ARC_BOUNDING_BOX_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARCBB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARCBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/arcbb_pkg.sv
// ----------------------------------------------------------------------------
// Arc bounding box package
// Shared widths, angle constants, quadrant and axis codes, the control
// struct passed from the angle unit and the elaboration-time sine series.
// ----------------------------------------------------------------------------
package arcbb_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF = 24;
  localparam int TRIG_FRAC_DEF  = 16;

  // Fixed field widths
  localparam int RADIUS_W = 20;
  localparam int ANGLE_W  = 9;
  localparam int SWEEP_W  = 10;
  localparam int STROKE_W = 16;
  localparam int RES_W    = 7;    // residue within a quadrant, 0..89

  // Angle constants in whole degrees
  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3QUART  = 270;
  localparam int DEG_FULL    = 360;
  localparam int NUM_AXES    = 4;

  // pi in Q48
  localparam logic [63:0] PI_Q48 = 64'h0003_243F_6A88_85A3;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Axis directions, in counter-clockwise order from +x
  localparam int AXIS_POS_X = 0;
  localparam int AXIS_POS_Y = 1;
  localparam int AXIS_NEG_X = 2;
  localparam int AXIS_NEG_Y = 3;

  typedef struct packed {
    logic [NUM_AXES-1:0] axis_hit;
    logic                cos_start_neg;
    logic                sin_start_neg;
    logic                cos_end_neg;
    logic                sin_end_neg;
  } angle_info_t;

  // Sine of d whole degrees (0..90) in Q1.frac, from a Q30 Taylor series.
  // Evaluated only at elaboration to build the constant table.
  function automatic logic [63:0] quarter_sine(input int unsigned d,
                                               input int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] one;
    longint      sum;
    one = 64'd1 << frac;
    if (d == 0) begin
      return 64'd0;
    end
    if (d >= DEG_QUARTER) begin
      return one;
    end
    x    = ((64'(d) * PI_Q48) / 64'd180 + (64'd1 << 17)) >> 18;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
    if (sum > longint'(one)) begin
      sum = longint'(one);
    end
    return 64'(sum);
  endfunction

endpackage

### sv/arc_bounding_box.sv
// ----------------------------------------------------------------------------
// Arc bounding box
// Axis-aligned bounding box of a stroked circular arc, one arc per cycle unless the pipe is full and stalled.
// ----------------------------------------------------------------------------
// The block takes one arc per clock cycle unless the pipe is full and
// stalled, and holds it in an input register: stage one reduces the angles
// and reads the quarter-wave cosine/sine table, stage two forms the four
// radius products, stage three adds them to the centre, takes min/max,
// applies axis crossings and widens by half the stroke width into the output
// register. Each stage holds only while the stage after it is full and
// stalled, so a waiting result does not block new arcs until the pipe is full.
`include "arc_bounding_box_macros.svh"

module arc_bounding_box #(
  parameter int COORD_BITS     = arcbb_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = arcbb_pkg::TRIG_FRAC_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          center_x,
  input  logic signed [COORD_BITS-1:0]          center_y,
  input  logic        [arcbb_pkg::RADIUS_W-1:0] radius,
  input  logic        [arcbb_pkg::ANGLE_W-1:0]  start_deg,
  input  logic signed [arcbb_pkg::SWEEP_W-1:0]  sweep_deg,
  input  logic        [arcbb_pkg::STROKE_W-1:0] stroke_width,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS+1:0]          box_left,
  output logic signed [COORD_BITS+1:0]          box_top,
  output logic signed [COORD_BITS+1:0]          box_right,
  output logic signed [COORD_BITS+1:0]          box_bottom
);
  import arcbb_pkg::*;

  localparam int OUT_W  = COORD_BITS + 2;
  localparam int WORK_W = ((COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W) + 3;
  localparam int TW     = TRIG_FRAC_BITS + 1;
  localparam int PROD_W = RADIUS_W + TW;
  localparam int HALF_W = STROKE_W - 1;

  // Pipeline enables
  logic adv0, adv1, adv2, adv3;

  // Stage 0: input register
  logic                         v0;
  logic signed [COORD_BITS-1:0] cx0, cy0;
  logic        [RADIUS_W-1:0]   r0;
  logic        [ANGLE_W-1:0]    st0;
  logic signed [SWEEP_W-1:0]    sw0;
  logic        [STROKE_W-1:0]   stroke0;

  // Angle unit outputs
  logic [TW-1:0] cos_s, sin_s, cos_e, sin_e;
  angle_info_t   info;

  // Stage 1: trig magnitudes
  logic                         v1;
  logic signed [COORD_BITS-1:0] cx1, cy1;
  logic        [RADIUS_W-1:0]   r1;
  logic        [HALF_W-1:0]     half1;
  logic        [TW-1:0]         cos_s1, sin_s1, cos_e1, sin_e1;
  angle_info_t                  info1;

  // Stage 2: radius products
  logic                         v2;
  logic signed [COORD_BITS-1:0] cx2, cy2;
  logic        [RADIUS_W-1:0]   r2;
  logic        [HALF_W-1:0]     half2;
  logic        [RADIUS_W-1:0]   dx_s2, dy_s2, dx_e2, dy_e2;
  angle_info_t                  info2;

  logic [PROD_W-1:0]   prod_xs, prod_ys, prod_xe, prod_ye;
  logic [RADIUS_W-1:0] dx_s_next, dy_s_next, dx_e_next, dy_e_next;

  logic signed [WORK_W-1:0] cxw, cyw, rw, hw;
  logic signed [WORK_W-1:0] x_s, y_s, x_e, y_e;
  logic signed [WORK_W-1:0] left_next, top_next, right_next, bottom_next;

  function automatic logic signed [WORK_W-1:0] signed_off(
    input logic [RADIUS_W-1:0] mag, input logic neg);
    logic signed [WORK_W-1:0] v;
    v = WORK_W'($signed({1'b0, mag}));
    return neg ? -v : v;
  endfunction

  function automatic logic signed [WORK_W-1:0] min3(
    input logic signed [WORK_W-1:0] a, input logic signed [WORK_W-1:0] b,
    input logic signed [WORK_W-1:0] c);
    logic signed [WORK_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [WORK_W-1:0] max3(
    input logic signed [WORK_W-1:0] a, input logic signed [WORK_W-1:0] b,
    input logic signed [WORK_W-1:0] c);
    logic signed [WORK_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Advance a stage when the one after it is empty or moving
  assign adv3     = !out_valid || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign adv0     = !v0 || adv1;
  assign in_ready = adv0;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv0) begin
      v0 <= in_valid;
    end
    if (adv0 && in_valid) begin
      cx0     <= center_x;
      cy0     <= center_y;
      r0      <= radius;
      st0     <= start_deg;
      sw0     <= sweep_deg;
      stroke0 <= stroke_width;
    end
  end

  arcbb_angle #(
    .FRAC_BITS (TRIG_FRAC_BITS)
  ) u_angle (
    .start_deg (st0),
    .sweep_deg (sw0),
    .cos_start (cos_s),
    .sin_start (sin_s),
    .cos_end   (cos_e),
    .sin_end   (sin_e),
    .info      (info)
  );

  // Hold the table results
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= v0;
    end
    if (adv1 && v0) begin
      cx1    <= cx0;
      cy1    <= cy0;
      r1     <= r0;
      half1  <= stroke0[STROKE_W-1:1];
      cos_s1 <= cos_s;
      sin_s1 <= sin_s;
      cos_e1 <= cos_e;
      sin_e1 <= sin_e;
      info1  <= info;
    end
  end

  // Scale the radius by each trig magnitude, truncating toward zero
  always_comb begin
    prod_xs   = PROD_W'(r1) * PROD_W'(cos_s1);
    prod_ys   = PROD_W'(r1) * PROD_W'(sin_s1);
    prod_xe   = PROD_W'(r1) * PROD_W'(cos_e1);
    prod_ye   = PROD_W'(r1) * PROD_W'(sin_e1);
    dx_s_next = RADIUS_W'(prod_xs >> TRIG_FRAC_BITS);
    dy_s_next = RADIUS_W'(prod_ys >> TRIG_FRAC_BITS);
    dx_e_next = RADIUS_W'(prod_xe >> TRIG_FRAC_BITS);
    dy_e_next = RADIUS_W'(prod_ye >> TRIG_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2 && v1) begin
      cx2   <= cx1;
      cy2   <= cy1;
      r2    <= r1;
      half2 <= half1;
      dx_s2 <= dx_s_next;
      dy_s2 <= dy_s_next;
      dx_e2 <= dx_e_next;
      dy_e2 <= dy_e_next;
      info2 <= info1;
    end
  end

  // Form end points, take extremes, apply crossings and widen
  always_comb begin
    cxw = WORK_W'(cx2);
    cyw = WORK_W'(cy2);
    rw  = WORK_W'($signed({1'b0, r2}));
    hw  = WORK_W'($signed({1'b0, half2}));
    x_s = cxw + signed_off(dx_s2, info2.cos_start_neg);
    y_s = cyw + signed_off(dy_s2, info2.sin_start_neg);
    x_e = cxw + signed_off(dx_e2, info2.cos_end_neg);
    y_e = cyw + signed_off(dy_e2, info2.sin_end_neg);
    right_next  = info2.axis_hit[AXIS_POS_X] ? cxw + rw : max3(cxw, x_s, x_e);
    bottom_next = info2.axis_hit[AXIS_POS_Y] ? cyw + rw : max3(cyw, y_s, y_e);
    left_next   = info2.axis_hit[AXIS_NEG_X] ? cxw - rw : min3(cxw, x_s, x_e);
    top_next    = info2.axis_hit[AXIS_NEG_Y] ? cyw - rw : min3(cyw, y_s, y_e);
    left_next   = left_next - hw;
    top_next    = top_next - hw;
    right_next  = right_next + hw;
    bottom_next = bottom_next + hw;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= v2;
    end
    if (adv3 && v2) begin
      box_left   <= left_next[OUT_W-1:0];
      box_top    <= top_next[OUT_W-1:0];
      box_right  <= right_next[OUT_W-1:0];
      box_bottom <= bottom_next[OUT_W-1:0];
    end
  end

  `ARCBB_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v0, "accepted arc not captured")
  `ARCBB_ASSERT_SAME(a_full_blocks, v0 && v1 && v2 && out_valid && !out_ready, !in_ready, "input taken while pipe is full and stalled")
  `ARCBB_ASSERT_SAME(a_zero_sweep, v0 && (sw0 == '0), info.axis_hit == '0, "zero sweep flagged an axis crossing")
  `ARCBB_ASSERT_NEXT(a_stage_hold, v2 && !adv3, v2 && $stable(r2) && $stable(dx_s2), "stalled product stage changed")

endmodule

### sv/arcbb_angle.sv
// ----------------------------------------------------------------------------
// Arc bounding box angle unit
// Reduces start and end angles, reads cosine and sine magnitudes from the
// quarter-wave table and flags the axis directions crossed by the sweep.
// ----------------------------------------------------------------------------
module arcbb_angle #(
  parameter int FRAC_BITS = arcbb_pkg::TRIG_FRAC_DEF
) (
  input  logic        [arcbb_pkg::ANGLE_W-1:0] start_deg,
  input  logic signed [arcbb_pkg::SWEEP_W-1:0] sweep_deg,
  output logic        [FRAC_BITS:0]            cos_start,
  output logic        [FRAC_BITS:0]            sin_start,
  output logic        [FRAC_BITS:0]            cos_end,
  output logic        [FRAC_BITS:0]            sin_end,
  output arcbb_pkg::angle_info_t               info
);
  import arcbb_pkg::*;

  localparam int TW    = FRAC_BITS + 1;
  localparam int SUM_W = 12;
  localparam int LIM_W = 11;

  localparam logic [ANGLE_W-1:0]      FULL_U   = ANGLE_W'(DEG_FULL);
  localparam logic signed [SUM_W-1:0] FULL_S   = SUM_W'(DEG_FULL);
  localparam logic signed [SUM_W-1:0] FULL2_S  = SUM_W'(2 * DEG_FULL);
  localparam logic signed [SUM_W-1:0] NFULL_S  = -SUM_W'(DEG_FULL);
  localparam logic [RES_W-1:0]        QUART_R  = RES_W'(DEG_QUARTER);

  // Quarter-wave sine table, built at elaboration
  logic [TW-1:0] sine_rom [0:DEG_QUARTER];

  for (genvar g = 0; g <= DEG_QUARTER; g++) begin : g_rom
    localparam logic [TW-1:0] VAL = TW'(quarter_sine(g, FRAC_BITS));
    assign sine_rom[g] = VAL;
  end

  // Split an angle 0..359 into quadrant and residue
  function automatic logic [RES_W+1:0] quad_split(input logic [ANGLE_W-1:0] a);
    quad_t          q;
    logic [RES_W-1:0] r;
    priority if (a >= ANGLE_W'(DEG_3QUART)) begin
      q = QUAD_IV;
      r = RES_W'(a - ANGLE_W'(DEG_3QUART));
    end else if (a >= ANGLE_W'(DEG_HALF)) begin
      q = QUAD_III;
      r = RES_W'(a - ANGLE_W'(DEG_HALF));
    end else if (a >= ANGLE_W'(DEG_QUARTER)) begin
      q = QUAD_II;
      r = RES_W'(a - ANGLE_W'(DEG_QUARTER));
    end else begin
      q = QUAD_I;
      r = RES_W'(a);
    end
    return {q, r};
  endfunction

  logic        [ANGLE_W-1:0] st;
  logic signed [SUM_W-1:0]   end_sum;
  logic signed [SUM_W-1:0]   end_red;
  logic        [ANGLE_W-1:0] en;
  logic                      cw;
  logic        [ANGLE_W-1:0] base;
  logic        [SWEEP_W-1:0] span;
  logic        [LIM_W-1:0]   lim;
  logic        [RES_W+1:0]   split_base;
  quad_t                     q_base;
  logic        [LIM_W-1:0]   ang0;
  logic        [LIM_W-1:0]   thr;
  logic        [1:0]         axis;
  logic        [NUM_AXES-1:0] axis_hit;
  logic        [RES_W+1:0]   split_st;
  logic        [RES_W+1:0]   split_en;
  quad_t                     q_st;
  quad_t                     q_en;
  logic        [RES_W-1:0]   r_st;
  logic        [RES_W-1:0]   r_en;
  logic        [TW-1:0]      lo_st;
  logic        [TW-1:0]      hi_st;
  logic        [TW-1:0]      lo_en;
  logic        [TW-1:0]      hi_en;

  // Reduce the start angle and form the end angle modulo a full turn
  always_comb begin
    st      = (start_deg >= FULL_U) ? ANGLE_W'(start_deg - FULL_U) : start_deg;
    end_sum = $signed({3'b000, st}) + SUM_W'(sweep_deg);
    priority if (end_sum < NFULL_S) begin
      end_red = end_sum + FULL2_S;
    end else if (end_sum < 0) begin
      end_red = end_sum + FULL_S;
    end else if (end_sum >= FULL2_S) begin
      end_red = end_sum - FULL2_S;
    end else if (end_sum >= FULL_S) begin
      end_red = end_sum - FULL_S;
    end else begin
      end_red = end_sum;
    end
    en = end_red[ANGLE_W-1:0];
  end

  // Turn a clockwise sweep around and flag axis crossings
  always_comb begin
    cw         = sweep_deg[SWEEP_W-1];
    base       = cw ? en : st;
    span       = cw ? SWEEP_W'(-sweep_deg) : SWEEP_W'(sweep_deg);
    lim        = LIM_W'(base) + LIM_W'(span);
    split_base = quad_split(base);
    q_base     = quad_t'(split_base[RES_W+1:RES_W]);
    unique case (q_base)
      QUAD_I:   ang0 = '0;
      QUAD_II:  ang0 = LIM_W'(DEG_QUARTER);
      QUAD_III: ang0 = LIM_W'(DEG_HALF);
      QUAD_IV:  ang0 = LIM_W'(DEG_3QUART);
      default:  ang0 = '0;
    endcase
    axis_hit = '0;
    thr      = ang0;
    axis     = 2'(q_base);
    for (int k = 0; k < NUM_AXES; k++) begin
      thr  = ang0 + LIM_W'(DEG_QUARTER * (k + 1));
      axis = 2'(q_base) + 2'(k + 1);
      if (thr < lim) begin
        axis_hit[axis] = 1'b1;
      end
    end
  end

  // Read table magnitudes and fold signs by quadrant
  always_comb begin
    split_st = quad_split(st);
    split_en = quad_split(en);
    q_st  = quad_t'(split_st[RES_W+1:RES_W]);
    r_st  = split_st[RES_W-1:0];
    q_en  = quad_t'(split_en[RES_W+1:RES_W]);
    r_en  = split_en[RES_W-1:0];
    lo_st = sine_rom[r_st];
    hi_st = sine_rom[QUART_R - r_st];
    lo_en = sine_rom[r_en];
    hi_en = sine_rom[QUART_R - r_en];
    info.axis_hit = axis_hit;
    unique case (q_st)
      QUAD_I: begin
        sin_start = lo_st; info.sin_start_neg = 1'b0;
        cos_start = hi_st; info.cos_start_neg = 1'b0;
      end
      QUAD_II: begin
        sin_start = hi_st; info.sin_start_neg = 1'b0;
        cos_start = lo_st; info.cos_start_neg = 1'b1;
      end
      QUAD_III: begin
        sin_start = lo_st; info.sin_start_neg = 1'b1;
        cos_start = hi_st; info.cos_start_neg = 1'b1;
      end
      default: begin
        sin_start = hi_st; info.sin_start_neg = 1'b1;
        cos_start = lo_st; info.cos_start_neg = 1'b0;
      end
    endcase
    unique case (q_en)
      QUAD_I: begin
        sin_end = lo_en; info.sin_end_neg = 1'b0;
        cos_end = hi_en; info.cos_end_neg = 1'b0;
      end
      QUAD_II: begin
        sin_end = hi_en; info.sin_end_neg = 1'b0;
        cos_end = lo_en; info.cos_end_neg = 1'b1;
      end
      QUAD_III: begin
        sin_end = lo_en; info.sin_end_neg = 1'b1;
        cos_end = hi_en; info.cos_end_neg = 1'b1;
      end
      default: begin
        sin_end = hi_en; info.sin_end_neg = 1'b1;
        cos_end = lo_en; info.cos_end_neg = 1'b0;
      end
    endcase
  end

endmodule
